// File: rtl/ipv4_frame_receive_checker_unit_assert.svh
// ---------------------------------------------------------------------------
// IPv4 frame receive checker assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef IPV4_FRAME_RECEIVE_CHECKER_UNIT_ASSERT_SVH
`define IPV4_FRAME_RECEIVE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IPV4RC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IPV4RC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ipv4rc_pkg.sv
// ---------------------------------------------------------------------------
// IPv4 frame receive checker package
// Request and result types, frame positions and verdict codes.
// ---------------------------------------------------------------------------
package ipv4rc_pkg;

  // Frame byte positions.
  localparam logic [5:0] POS_TYPE_HI  = 6'd12;
  localparam logic [5:0] POS_TYPE_LO  = 6'd13;
  localparam logic [5:0] HDR_START    = 6'd14;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_CHECK_LO = 6'd25;
  localparam logic [5:0] HDR_END      = 6'd34;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Verdict codes.
  localparam logic [3:0] VERDICT_OTHER_TYPE  = 4'd0;
  localparam logic [3:0] VERDICT_ARP         = 4'd1;
  localparam logic [3:0] VERDICT_TOO_SHORT   = 4'd2;
  localparam logic [3:0] VERDICT_BAD_VERSION = 4'd3;
  localparam logic [3:0] VERDICT_BAD_CHECK   = 4'd4;
  localparam logic [3:0] VERDICT_ICMP        = 4'd5;
  localparam logic [3:0] VERDICT_TCP         = 4'd6;
  localparam logic [3:0] VERDICT_UDP         = 4'd7;
  localparam logic [3:0] VERDICT_OTHER_PROTO = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic [7:0] protocol_number;
  } out_item_t;

  // Frame state as it stands after the current byte has been taken.
  typedef struct packed {
    logic [5:0]  count;
    logic [15:0] frame_type;
    logic [3:0]  version_nibble;
    logic [7:0]  protocol_held;
    logic [15:0] word_sum;
    logic [15:0] received_check;
  } frame_view_t;

endpackage

// File: rtl/ipv4rc_parse.sv
// ---------------------------------------------------------------------------
// IPv4 frame receive checker byte parser
// Holds the per-frame state and folds each byte into it.
// ---------------------------------------------------------------------------
module ipv4rc_parse import ipv4rc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  in_item_t    item,
  output frame_view_t view
);

  logic [5:0]  byte_position;
  logic [15:0] frame_type;
  logic [3:0]  version_nibble;
  logic [7:0]  protocol_held;
  logic [15:0] word_sum;
  logic [15:0] received_check;
  logic [7:0]  high_byte_hold;
  logic [7:0]  high_byte_hold_next;

  logic        in_hdr;
  logic [15:0] word;
  logic [16:0] sum_wide;

  always_comb begin
    in_hdr   = (byte_position >= HDR_START) && (byte_position < HDR_END);
    word     = {high_byte_hold, item.data_byte};
    sum_wide = {1'b0, word_sum} + {1'b0, word};

    view                = '0;
    view.count          = byte_position;
    view.frame_type     = frame_type;
    view.version_nibble = version_nibble;
    view.protocol_held  = protocol_held;
    view.word_sum       = word_sum;
    view.received_check = received_check;
    high_byte_hold_next = high_byte_hold;

    if (byte_position < HDR_END) begin
      view.count = byte_position + 6'd1;
    end
    if (byte_position == POS_TYPE_HI) begin
      view.frame_type = {item.data_byte, 8'h00};
    end else if (byte_position == POS_TYPE_LO) begin
      view.frame_type = {frame_type[15:8], item.data_byte};
    end
    if (in_hdr) begin
      if (byte_position == HDR_START) begin
        view.version_nibble = item.data_byte[7:4];
      end
      if (byte_position == POS_PROTO) begin
        view.protocol_held = item.data_byte;
      end
      if (!byte_position[0]) begin
        high_byte_hold_next = item.data_byte;
      end else if (byte_position == POS_CHECK_LO) begin
        view.received_check = word;
      end else begin
        // End-around carry keeps the running sum folded to 16 bits.
        view.word_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last_byte)) begin
      byte_position  <= '0;
      frame_type     <= '0;
      version_nibble <= '0;
      protocol_held  <= '0;
      word_sum       <= '0;
      received_check <= '0;
      high_byte_hold <= '0;
    end else if (take) begin
      byte_position  <= view.count;
      frame_type     <= view.frame_type;
      version_nibble <= view.version_nibble;
      protocol_held  <= view.protocol_held;
      word_sum       <= view.word_sum;
      received_check <= view.received_check;
      high_byte_hold <= high_byte_hold_next;
    end
  end

endmodule

// File: rtl/ipv4rc_classify.sv
// ---------------------------------------------------------------------------
// IPv4 frame receive checker classifier
// Turns the finished frame state into one verdict.
// ---------------------------------------------------------------------------
module ipv4rc_classify import ipv4rc_pkg::*; (
  input  frame_view_t view,
  output out_item_t   result
);

  logic [15:0] computed_check;

  always_comb begin
    computed_check = ~view.word_sum;
    result         = '0;
    if (view.count < HDR_START) begin
      result.verdict = VERDICT_TOO_SHORT;
    end else if (view.frame_type == TYPE_IPV4) begin
      if (view.count > POS_PROTO) begin
        result.protocol_number = view.protocol_held;
      end
      if (view.count < HDR_END) begin
        result.verdict = VERDICT_TOO_SHORT;
      end else if (view.version_nibble != IP_VERSION_4) begin
        result.verdict = VERDICT_BAD_VERSION;
      end else if (computed_check != view.received_check) begin
        result.verdict = VERDICT_BAD_CHECK;
      end else begin
        case (view.protocol_held)
          PROTO_ICMP: result.verdict = VERDICT_ICMP;
          PROTO_TCP:  result.verdict = VERDICT_TCP;
          PROTO_UDP:  result.verdict = VERDICT_UDP;
          default:    result.verdict = VERDICT_OTHER_PROTO;
        endcase
      end
    end else if (view.frame_type == TYPE_ARP) begin
      result.verdict = VERDICT_ARP;
    end else begin
      result.verdict = VERDICT_OTHER_TYPE;
    end
  end

endmodule

// File: rtl/ipv4_frame_receive_checker_unit.sv
// ---------------------------------------------------------------------------
// IPv4 frame receive checker
// Checks the IPv4 header of an Ethernet frame fed one byte per request.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  -------------------------------------
//   in       in_valid / in_ready   in_data  : data_byte, last_byte
//   out      out_valid / out_ready out_data : verdict, protocol_number
//
// One byte request is taken per cycle unless a last byte waits behind a
// stalled verdict. A request lands in the input register. When it
// advances it is folded into the frame state, and the verdict for a last
// byte is written to the result register, which offers it on the output.
// The rate is set by the checksum accumulate in the parser.
// Reset is synchronous and returns all frame state to the start of a frame.
// A stalled result only holds back the pipeline when a last byte is waiting.
//
`include "ipv4_frame_receive_checker_unit_assert.svh"

module ipv4_frame_receive_checker_unit import ipv4rc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Input register.
  in_item_t    in_q;
  logic        in_q_valid;

  // Result register.
  out_item_t   res;
  logic        res_valid;

  logic        advance;
  frame_view_t view;
  out_item_t   result;

  // A byte without the last flag never needs the result register, so it
  // moves on even while a verdict is stalled at the output.
  assign advance  = in_q_valid && (!in_q.last_byte || !res_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  ipv4rc_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (advance),
    .item (in_q),
    .view (view)
  );

  ipv4rc_classify u_classify (
    .view   (view),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_q.last_byte) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.last_byte) begin
      res <= result;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res;

  // A last byte that moves on must leave a verdict behind it.
  `IPV4RC_ASSERT_NEXT(a_last_gives_result, clk, rst,
    advance && in_q.last_byte, res_valid, "last byte left no verdict")

  // A byte without the last flag must not create a verdict.
  `IPV4RC_ASSERT_NEXT(a_no_invented_result, clk, rst,
    !res_valid && !(advance && in_q.last_byte), !res_valid,
    "verdict appeared without a last byte")

  // Verdict codes stop at the other-protocol code.
  `IPV4RC_ASSERT_SAME(a_verdict_range, clk, rst,
    res_valid, res.verdict <= VERDICT_OTHER_PROTO, "verdict code out of range")

  // Frames that are not IPv4 never report a protocol byte.
  `IPV4RC_ASSERT_SAME(a_non_ip_no_proto, clk, rst,
    res_valid && (res.verdict == VERDICT_ARP || res.verdict == VERDICT_OTHER_TYPE),
    res.protocol_number == 8'd0, "protocol reported for non-IPv4 frame")

endmodule
